// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the task scheduler.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is low
`define TDTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset
`define TDTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/tdts_pkg.sv
// Package of the tick driven task scheduler: sizes, codes, FSM and table types.
// No dependencies; used by tdts_slot_table and tick_driven_task_scheduler.
package tdts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TIME_W    = 32;
  localparam int ID_W      = 8;
  localparam int PRIO_W    = 8;
  localparam int LEFT_W    = 16;
  localparam int POLICY_W  = 2;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  // policy register codes (code 3 behaves as preemptive)
  localparam logic [POLICY_W-1:0] POLICY_FCFS  = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_NPRIO = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_PRIO  = 2'd2;

  // request and status codes
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;
  localparam logic STAT_DONE  = 1'b0;
  localparam logic STAT_FULL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_SCAN,
    ST_SERVE
  } state_t;

  // one ready table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] start;
    logic [LEFT_W-1:0] left;
  } slot_t;

  // table write port
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

endpackage

// File: rtl/tick_driven_task_scheduler.sv
// Top level of the tick driven task scheduler (FCFS / priority).
// Depends on tdts_pkg, tdts_slot_table and assert_macros.svh.
//
// The block takes one item at a time. An arrival is accepted, then inserted into the lowest
// free slot or rejected. A tick goes straight to serve when a non-preemptive policy keeps
// the running task; otherwise one shared comparator walks all MAX_TASKS slots of the ready
// table, one slot per cycle, to find the winner, and the serve state then serves it.
// An idle tick on an empty table skips the serve state.
// A result sits in an output register; the block accepts the next item while it waits and
// only holds a step that has a new result until the previous one has been transferred.
`include "assert_macros.svh"
module tick_driven_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_run_time,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [7:0]  out_task_id,
  output logic [7:0]  out_priority,
  output logic [31:0] out_arrival_time,
  output logic [31:0] out_start_time,
  output logic [31:0] out_finish_time
);

  localparam int N  = tdts_pkg::MAX_TASKS;
  localparam int SW = tdts_pkg::SLOT_W;
  localparam int TW = tdts_pkg::TIME_W;

  // control state
  tdts_pkg::state_t              state_r, state_nxt;
  logic [tdts_pkg::POLICY_W-1:0] policy_r;
  logic [TW-1:0]                 now_r, now_nxt;
  logic [N-1:0]                  valid_r, valid_nxt;
  logic [N-1:0]                  started_r, started_nxt;
  logic [SW-1:0]                 run_slot_r, run_slot_nxt;
  logic                          run_busy_r, run_busy_nxt;
  logic [SW-1:0]                 idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // payload registers
  logic                          req_r;
  logic [tdts_pkg::ID_W-1:0]     id_r;
  logic [tdts_pkg::PRIO_W-1:0]   prio_r;
  logic [tdts_pkg::LEFT_W-1:0]   rt_r;
  logic [SW-1:0]                 best_r, best_nxt;
  logic [tdts_pkg::PRIO_W-1:0]   best_prio_r, best_prio_nxt;
  logic [TW-1:0]                 best_arr_r, best_arr_nxt;
  logic                          o_status_r, o_status_nxt;
  logic [7:0]                    o_id_r, o_id_nxt;
  logic [7:0]                    o_prio_r, o_prio_nxt;
  logic [TW-1:0]                 o_arr_r, o_arr_nxt;
  logic [TW-1:0]                 o_start_r, o_start_nxt;
  logic [TW-1:0]                 o_fin_r, o_fin_nxt;

  // table port
  tdts_pkg::slot_wr_t wr;
  tdts_pkg::slot_t    rd;
  logic [SW-1:0]      rd_addr;

  // shared decisions
  logic                        in_xfer, out_free, by_prio, preempt, keep_running;
  logic                        cand_wins, take, scan_last, serve_done, free_any;
  logic [SW-1:0]               free_idx;
  logic [tdts_pkg::LEFT_W-1:0] left_dec;
  logic [TW-1:0]               now_inc, start_val;

  tdts_slot_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  assign in_ready = (state_r == tdts_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign by_prio  = (policy_r != tdts_pkg::POLICY_FCFS);
  assign preempt  = (policy_r >= tdts_pkg::POLICY_PRIO);
  assign keep_running = !preempt && run_busy_r && valid_r[run_slot_r];
  assign now_inc  = (now_r == tdts_pkg::TIME_TOP) ? now_r : now_r + TW'(1);
  // table read is registered: address the slot needed in the next cycle
  assign rd_addr  = (state_nxt == tdts_pkg::ST_SCAN) ? idx_nxt : best_nxt;

  // shared comparator: lower slots are visited first, so equal arrival never wins
  assign cand_wins = (by_prio && (rd.prio != best_prio_r)) ? (rd.prio > best_prio_r)
                                                          : (rd.arrival < best_arr_r);
  assign take      = valid_r[idx_r] && (!found_r || cand_wins);
  assign scan_last = (idx_r == SW'(N - 1));

  // serve arithmetic
  assign left_dec   = (rd.left != '0) ? rd.left - tdts_pkg::LEFT_W'(1) : '0;
  assign serve_done = (left_dec == '0);
  assign start_val  = started_r[best_r] ? rd.start : now_r;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_req_type == tdts_pkg::REQ_ARRIVE) state_nxt = tdts_pkg::ST_ARRIVE;
          else if (keep_running)                    state_nxt = tdts_pkg::ST_SERVE;
          else                                      state_nxt = tdts_pkg::ST_SCAN;
        end
      end
      tdts_pkg::ST_ARRIVE: begin
        if (free_any || out_free) state_nxt = tdts_pkg::ST_IDLE;
      end
      tdts_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = (found_r || take) ? tdts_pkg::ST_SERVE : tdts_pkg::ST_IDLE;
        end
      end
      tdts_pkg::ST_SERVE: begin
        if (!serve_done || out_free) state_nxt = tdts_pkg::ST_IDLE;
      end
      default: state_nxt = tdts_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    started_nxt   = started_r;
    run_slot_nxt  = run_slot_r;
    run_busy_nxt  = run_busy_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    best_arr_nxt  = best_arr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt  = o_status_r;
    o_id_nxt      = o_id_r;
    o_prio_nxt    = o_prio_r;
    o_arr_nxt     = o_arr_r;
    o_start_nxt   = o_start_r;
    o_fin_nxt     = o_fin_r;
    wr            = '0;
    wr.addr       = best_r;
    wr.data       = rd;
    case (state_r)
      tdts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (keep_running) best_nxt = run_slot_r;
        end
      end
      tdts_pkg::ST_ARRIVE: begin
        if (free_any) begin
          wr.en                = 1'b1;
          wr.addr              = free_idx;
          wr.data.id           = id_r;
          wr.data.prio         = prio_r;
          wr.data.arrival      = now_r;
          wr.data.start        = '0;
          wr.data.left         = (rt_r == '0) ? tdts_pkg::LEFT_W'(1) : rt_r;
          valid_nxt[free_idx]   = 1'b1;
          started_nxt[free_idx] = 1'b0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = tdts_pkg::STAT_FULL;
          o_id_nxt      = id_r;
          o_prio_nxt    = prio_r;
          o_arr_nxt     = now_r;
          o_start_nxt   = '0;
          o_fin_nxt     = '0;
        end
      end
      tdts_pkg::ST_SCAN: begin
        if (take) begin
          best_nxt      = idx_r;
          best_prio_nxt = rd.prio;
          best_arr_nxt  = rd.arrival;
          found_nxt     = 1'b1;
        end
        idx_nxt = idx_r + SW'(1);
        // idle tick: nothing ready
        if (scan_last && !(found_r || take)) begin
          run_busy_nxt = 1'b0;
          now_nxt      = now_inc;
        end
      end
      tdts_pkg::ST_SERVE: begin
        if (!serve_done) begin
          wr.en               = 1'b1;
          wr.data.start       = start_val;
          wr.data.left        = left_dec;
          started_nxt[best_r] = 1'b1;
          run_slot_nxt        = best_r;
          run_busy_nxt        = 1'b1;
          now_nxt             = now_inc;
        end else if (out_free) begin
          out_valid_nxt       = 1'b1;
          o_status_nxt        = tdts_pkg::STAT_DONE;
          o_id_nxt            = rd.id;
          o_prio_nxt          = rd.prio;
          o_arr_nxt           = rd.arrival;
          o_start_nxt         = start_val;
          o_fin_nxt           = now_inc;
          valid_nxt[best_r]   = 1'b0;
          started_nxt[best_r] = 1'b0;
          run_slot_nxt        = '0;
          run_busy_nxt        = 1'b0;
          now_nxt             = now_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdts_pkg::ST_IDLE;
      policy_r    <= tdts_pkg::POLICY_FCFS;
      now_r       <= '0;
      valid_r     <= '0;
      started_r   <= '0;
      run_slot_r  <= '0;
      run_busy_r  <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) policy_r <= cfg_wr_data;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      started_r   <= started_nxt;
      run_slot_r  <= run_slot_nxt;
      run_busy_r  <= run_busy_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r  <= in_req_type;
      id_r   <= in_task_id;
      prio_r <= in_task_priority;
      rt_r   <= in_run_time;
    end
    best_r      <= best_nxt;
    best_prio_r <= best_prio_nxt;
    best_arr_r  <= best_arr_nxt;
    o_status_r  <= o_status_nxt;
    o_id_r      <= o_id_nxt;
    o_prio_r    <= o_prio_nxt;
    o_arr_r     <= o_arr_nxt;
    o_start_r   <= o_start_nxt;
    o_fin_r     <= o_fin_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_task_id      = o_id_r;
  assign out_priority     = o_prio_r;
  assign out_arrival_time = o_arr_r;
  assign out_start_time   = o_start_r;
  assign out_finish_time  = o_fin_r;

  // checks
  `TDTS_ASSERT(a_busy_slot_valid, clk, rst_n,
               run_busy_r |-> valid_r[run_slot_r], "running task has no valid slot")
  `TDTS_ASSERT(a_best_valid, clk, rst_n,
               (state_r == tdts_pkg::ST_SCAN && found_r) |-> valid_r[best_r],
               "scan winner slot not valid")
  `TDTS_ASSERT(a_time_saturates, clk, rst_n,
               (now_r == tdts_pkg::TIME_TOP) |=> (now_r == tdts_pkg::TIME_TOP),
               "time counter wrapped")
  `TDTS_ASSERT(a_arrive_is_arrival, clk, rst_n,
               (state_r == tdts_pkg::ST_ARRIVE) |-> (req_r == tdts_pkg::REQ_ARRIVE),
               "insert step on a tick")

endmodule

// File: rtl/tdts_slot_table.sv
// Ready table payload storage: one write port, one registered read port.
// Depends on tdts_pkg for the entry and write port types.
module tdts_slot_table (
  input  logic                      clk,
  input  tdts_pkg::slot_wr_t        wr,
  input  logic [tdts_pkg::SLOT_W-1:0] rd_addr,
  output tdts_pkg::slot_t           rd_data
);

  tdts_pkg::slot_t entry_r [tdts_pkg::MAX_TASKS];

  // payload write, no reset: validity lives in the scheduler
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_r[wr.addr] <= wr.data;
    end
  end

  // registered read; the caller presents the address for the next cycle
  always_ff @(posedge clk) begin
    rd_data <= entry_r[rd_addr];
  end

endmodule
